// ===== sv/lavm_pkg.sv =====
// Shared types, constants and helper functions for the look-at view matrix unit.
package lavm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] entry_a;
    logic signed [31:0] entry_b;
    logic signed [31:0] entry_c;
    logic               last_row;
    logic               degenerate;
  } out_res_t;

  // Register stages of the normalizer: magnitude, five shift steps, squares, sum,
  // 32 root steps, FRAC_BITS+1 quotient steps and the sign stage.
  function automatic int norm_lat(input int frac);
    return 42 + frac;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [69:0] v);
    if (v > $signed(70'h0_7fff_ffff)) begin
      return 32'h7fff_ffff;
    end else if (v < -$signed(70'h0_8000_0000)) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== sv/lavm_norm.sv =====
// Pipelined three-component vector normalizer with integer square root and long division.
module lavm_norm
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic [2:0][63:0] c_i,
  output logic [2:0][31:0] n_o,
  output logic             zero_o
);

  localparam int NL = norm_lat(FRAC_BITS);
  localparam logic [62:0] LIM = 63'h0_8000_0000;

  logic [62:0] mag_r [3];
  logic [2:0]  sgl_r [NL-1];
  logic [62:0] sh_r [5][3];
  logic [31:0] ml_r [34][3];
  logic [63:0] sq_r [3];
  logic [63:0] sum_r;
  logic        zl_r [FRAC_BITS+33];
  logic [63:0] sv_r [32];
  logic [33:0] srem_r [32];
  logic [31:0] sroot_r [32];
  logic [33:0] dr_r [FRAC_BITS+1][3];
  logic [FRAC_BITS:0] dq_r [FRAC_BITS+1][3];
  logic [31:0] dlen_r [FRAC_BITS+1];
  logic [2:0][31:0] n_r;
  logic        zero_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= c_i[k][63] ? 63'(-c_i[k]) : c_i[k][62:0];
      sgl_r[0][k] <= c_i[k][63];
    end
    for (int i = 1; i < NL - 1; i++) begin
      sgl_r[i] <= sgl_r[i-1];
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_shift
    localparam int SH = 16 >> j;
    logic [62:0] v_in [3];
    logic        big;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        v_in[k] = (j == 0) ? mag_r[k] : sh_r[(j == 0) ? 0 : j-1][k];
      end
      big = ((v_in[0] >> (SH - 1)) > LIM) || ((v_in[1] >> (SH - 1)) > LIM) ||
            ((v_in[2] >> (SH - 1)) > LIM);
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        sh_r[j][k] <= big ? (v_in[k] >> SH) : v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ml_r[0][k] <= sh_r[4][k][31:0];
      sq_r[k] <= sh_r[4][k][31:0] * sh_r[4][k][31:0];
    end
    for (int i = 1; i < 34; i++) begin
      ml_r[i] <= ml_r[i-1];
    end
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    zl_r[0] <= (sum_r == 64'd0);
    for (int i = 1; i < FRAC_BITS + 33; i++) begin
      zl_r[i] <= zl_r[i-1];
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int P = 31 - j;
    logic [63:0] v_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rem_t;
    logic [35:0] trial;
    logic        ge;
    always_comb begin
      v_in    = (j == 0) ? sum_r : sv_r[(j == 0) ? 0 : j-1];
      rem_in  = (j == 0) ? 34'd0 : srem_r[(j == 0) ? 0 : j-1];
      root_in = (j == 0) ? 32'd0 : sroot_r[(j == 0) ? 0 : j-1];
      rem_t   = {rem_in, v_in[2*P+1:2*P]};
      trial   = {2'b00, root_in, 2'b01};
      ge      = (rem_t >= trial);
    end
    always_ff @(posedge clk) begin
      sv_r[j]    <= v_in;
      srem_r[j]  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
      sroot_r[j] <= {root_in[30:0], ge};
    end
  end

  for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_div
    logic [31:0] len_in;
    logic [33:0] r_t [3];
    logic [FRAC_BITS:0] q_in [3];
    logic [2:0]  ge;
    always_comb begin
      len_in = (g == 0) ? sroot_r[31] : dlen_r[(g == 0) ? 0 : g-1];
      for (int k = 0; k < 3; k++) begin
        if (g == 0) begin
          r_t[k]  = {2'b00, ml_r[33][k]};
          q_in[k] = '0;
        end else begin
          r_t[k]  = {dr_r[(g == 0) ? 0 : g-1][k][32:0], 1'b0};
          q_in[k] = dq_r[(g == 0) ? 0 : g-1][k];
        end
        ge[k] = (r_t[k] >= {2'b00, len_in});
      end
    end
    always_ff @(posedge clk) begin
      dlen_r[g] <= len_in;
      for (int k = 0; k < 3; k++) begin
        dr_r[g][k] <= ge[k] ? 34'(r_t[k] - {2'b00, len_in}) : r_t[k];
        dq_r[g][k] <= {q_in[k][FRAC_BITS-1:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zl_r[FRAC_BITS+32];
    for (int k = 0; k < 3; k++) begin
      if (zl_r[FRAC_BITS+32]) begin
        n_r[k] <= '0;
      end else if (sgl_r[NL-2][k]) begin
        n_r[k] <= -32'(dq_r[FRAC_BITS][k]);
      end else begin
        n_r[k] <= 32'(dq_r[FRAC_BITS][k]);
      end
    end
  end

  assign n_o    = n_r;
  assign zero_o = zero_r;

endmodule

// ===== sv/look_at_view_matrix_unit.sv =====
// Top level of the fixed-point look-at view matrix unit.
// A request is taken when start is high and busy is low. It carries the eye
// position, the view direction and the up vector in signed fixed point.
// Each request yields four results, rows 0 to 3 of the view matrix, on
// consecutive cycles, each marked by out_valid for one cycle; last_row marks
// row 3 and degenerate is set on all rows when a vector has zero length.
// Row 0 comes out after the depth of two normalizers in series plus the
// cross product and dot product stages around them.
// A new request is taken only once busy is low again, which paces requests
// to the four results on the single result channel; busy goes high after
// each accepted request. Requests are overlapped in the pipeline.
// Reset clears all valid bits, the busy count and the row sequencer; no
// result comes out of data that was in flight. Results cannot be held off
// and the pipeline never stalls.
module look_at_view_matrix_unit
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int NL = norm_lat(FRAC_BITS);
  localparam int VL = 2 * NL + 6;

  in_req_t          in_r;
  logic             in_v_r;
  logic [1:0]       bcnt_r;
  logic [VL-1:0]    vl_r;
  logic [2:0][63:0] n1_c;
  logic [2:0][31:0] n1_n;
  logic             n1_z;
  logic [2:0][63:0] n2_c;
  logic [2:0][31:0] n2_n;
  logic             n2_z;
  logic signed [31:0] upl_r [NL][3];
  logic signed [32:0] el_r [2*NL+2][3];
  logic signed [31:0] dl_r [NL+2][3];
  logic               dzl_r [NL+2];
  logic signed [31:0] d_c [3];
  logic signed [63:0] px_r [6];
  logic signed [63:0] sc_r [3];
  logic signed [31:0] s_c [3];
  logic signed [63:0] pa_r [6];
  logic signed [65:0] se_r [3];
  logic signed [65:0] de_r [3];
  logic signed [31:0] s1_r [3];
  logic signed [31:0] d1_r [3];
  logic signed [32:0] e1_r [3];
  logic               deg1_r;
  logic signed [33:0] t2_r [3];
  logic signed [67:0] sd2_r;
  logic signed [67:0] dd2_r;
  logic signed [31:0] s2_r [3];
  logic signed [31:0] d2_r [3];
  logic signed [32:0] e2_r [3];
  logic               deg2_r;
  logic signed [66:0] te3_r [3];
  logic signed [33:0] t3_r [3];
  logic signed [67:0] sd3_r;
  logic signed [67:0] dd3_r;
  logic signed [31:0] s3_r [3];
  logic signed [31:0] d3_r [3];
  logic               deg3_r;
  logic [31:0]        row_r [4][3];
  logic               deg4_r;
  logic [31:0]        hold_r [4][3];
  logic               hdeg_r;
  logic [1:0]         sc_cnt_r;
  logic [1:0]         sc_cnt_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_res_t           out_res_r;
  out_res_t           out_res_nxt;
  logic signed [64:0] t_diff [3];
  logic signed [67:0] sd_sum;
  logic signed [67:0] dd_sum;
  logic signed [68:0] td_sum;
  logic signed [68:0] td_c;
  logic               accept;
  logic               fin_v;

  assign accept = start && !busy;
  assign busy   = (bcnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      bcnt_r <= 2'd0;
      vl_r   <= '0;
    end else begin
      in_v_r <= accept;
      vl_r   <= {vl_r[VL-2:0], in_v_r};
      if (accept) begin
        bcnt_r <= 2'd3;
      end else if (bcnt_r != 2'd0) begin
        bcnt_r <= bcnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_req;
  end

  assign n1_c[0] = {{32{in_r.dir_x[31]}}, in_r.dir_x};
  assign n1_c[1] = {{32{in_r.dir_y[31]}}, in_r.dir_y};
  assign n1_c[2] = {{32{in_r.dir_z[31]}}, in_r.dir_z};

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_dir (
    .clk    (clk),
    .c_i    (n1_c),
    .n_o    (n1_n),
    .zero_o (n1_z)
  );

  always_comb begin
    d_c[0] = n1_n[0];
    d_c[1] = -n1_n[1];
    d_c[2] = n1_n[2];
  end

  always_ff @(posedge clk) begin
    upl_r[0][0] <= in_r.up_x;
    upl_r[0][1] <= in_r.up_y;
    upl_r[0][2] <= in_r.up_z;
    for (int i = 1; i < NL; i++) begin
      upl_r[i] <= upl_r[i-1];
    end
    el_r[0][0] <= 33'(in_r.eye_x);
    el_r[0][1] <= -33'(in_r.eye_y);
    el_r[0][2] <= 33'(in_r.eye_z);
    for (int i = 1; i < 2 * NL + 2; i++) begin
      el_r[i] <= el_r[i-1];
    end
    dl_r[0]  <= d_c;
    dzl_r[0] <= n1_z;
    for (int i = 1; i < NL + 2; i++) begin
      dl_r[i]  <= dl_r[i-1];
      dzl_r[i] <= dzl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    px_r[0] <= upl_r[NL-1][1] * d_c[2];
    px_r[1] <= upl_r[NL-1][2] * d_c[1];
    px_r[2] <= upl_r[NL-1][2] * d_c[0];
    px_r[3] <= upl_r[NL-1][0] * d_c[2];
    px_r[4] <= upl_r[NL-1][0] * d_c[1];
    px_r[5] <= upl_r[NL-1][1] * d_c[0];
    sc_r[0] <= px_r[0] - px_r[1];
    sc_r[1] <= px_r[2] - px_r[3];
    sc_r[2] <= px_r[4] - px_r[5];
  end

  assign n2_c[0] = sc_r[0];
  assign n2_c[1] = sc_r[1];
  assign n2_c[2] = sc_r[2];

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk    (clk),
    .c_i    (n2_c),
    .n_o    (n2_n),
    .zero_o (n2_z)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_c[k] = n2_n[k];
    end
    t_diff[0] = 65'(pa_r[0]) - 65'(pa_r[1]);
    t_diff[1] = 65'(pa_r[2]) - 65'(pa_r[3]);
    t_diff[2] = 65'(pa_r[4]) - 65'(pa_r[5]);
    sd_sum = -(68'(se_r[0]) + 68'(se_r[1]) + 68'(se_r[2]));
    dd_sum = -(68'(de_r[0]) + 68'(de_r[1]) + 68'(de_r[2]));
    td_sum = -(69'(te3_r[0]) + 69'(te3_r[1]) + 69'(te3_r[2]));
    td_c   = td_sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    pa_r[0] <= s_c[1] * dl_r[NL+1][2];
    pa_r[1] <= s_c[2] * dl_r[NL+1][1];
    pa_r[2] <= s_c[2] * dl_r[NL+1][0];
    pa_r[3] <= s_c[0] * dl_r[NL+1][2];
    pa_r[4] <= s_c[0] * dl_r[NL+1][1];
    pa_r[5] <= s_c[1] * dl_r[NL+1][0];
    for (int k = 0; k < 3; k++) begin
      se_r[k] <= 66'(s_c[k]) * 66'(el_r[2*NL+1][k]);
      de_r[k] <= 66'(dl_r[NL+1][k]) * 66'(el_r[2*NL+1][k]);
    end
    s1_r   <= s_c;
    d1_r   <= dl_r[NL+1];
    e1_r   <= el_r[2*NL+1];
    deg1_r <= dzl_r[NL+1] || n2_z;

    for (int k = 0; k < 3; k++) begin
      t2_r[k] <= 34'(t_diff[k] >>> FRAC_BITS);
    end
    sd2_r  <= sd_sum >>> FRAC_BITS;
    dd2_r  <= dd_sum >>> FRAC_BITS;
    s2_r   <= s1_r;
    d2_r   <= d1_r;
    e2_r   <= e1_r;
    deg2_r <= deg1_r;

    for (int k = 0; k < 3; k++) begin
      te3_r[k] <= 67'(t2_r[k]) * 67'(e2_r[k]);
    end
    t3_r   <= t2_r;
    sd3_r  <= sd2_r;
    dd3_r  <= dd2_r;
    s3_r   <= s2_r;
    d3_r   <= d2_r;
    deg3_r <= deg2_r;

    row_r[0][0] <= sat32(70'(s3_r[0]));
    row_r[0][1] <= sat32(70'(t3_r[0]));
    row_r[0][2] <= sat32(70'(d3_r[0]));
    row_r[1][0] <= sat32(-70'(s3_r[1]));
    row_r[1][1] <= sat32(-70'(t3_r[1]));
    row_r[1][2] <= sat32(-70'(d3_r[1]));
    row_r[2][0] <= sat32(70'(s3_r[2]));
    row_r[2][1] <= sat32(70'(t3_r[2]));
    row_r[2][2] <= sat32(70'(d3_r[2]));
    row_r[3][0] <= sat32(70'(sd3_r));
    row_r[3][1] <= sat32(70'(td_c));
    row_r[3][2] <= sat32(70'(dd3_r));
    deg4_r <= deg3_r;
  end

  assign fin_v = vl_r[VL-1];

  always_ff @(posedge clk) begin
    if (fin_v) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          hold_r[r][k] <= deg4_r ? 32'd0 : row_r[r][k];
        end
      end
      hdeg_r <= deg4_r;
    end
  end

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = 1'b0;
    sc_cnt_nxt    = sc_cnt_r;
    if (fin_v) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.row_index  = 2'd0;
      out_res_nxt.entry_a    = deg4_r ? 32'd0 : row_r[0][0];
      out_res_nxt.entry_b    = deg4_r ? 32'd0 : row_r[0][1];
      out_res_nxt.entry_c    = deg4_r ? 32'd0 : row_r[0][2];
      out_res_nxt.last_row   = 1'b0;
      out_res_nxt.degenerate = deg4_r;
      sc_cnt_nxt             = 2'd1;
    end else if (sc_cnt_r != 2'd0) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.row_index  = sc_cnt_r;
      out_res_nxt.entry_a    = hold_r[sc_cnt_r][0];
      out_res_nxt.entry_b    = hold_r[sc_cnt_r][1];
      out_res_nxt.entry_c    = hold_r[sc_cnt_r][2];
      out_res_nxt.last_row   = (sc_cnt_r == 2'd3);
      out_res_nxt.degenerate = hdeg_r;
      sc_cnt_nxt             = sc_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sc_cnt_r    <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sc_cnt_r    <= sc_cnt_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
